// ===== src/cs_pkg.sv =====
// shared types and constants for the cosine similarity core
// no dependencies; every other file in src uses this package
`default_nettype none

package cs_pkg;

  localparam int ELEM_W      = 16;
  localparam int SIM_W       = 16;
  localparam int TINY_W      = 21;
  localparam int QUEUE_DEPTH = 2;

  // quotient of dot^2 * 2^32 / (aa * bb), bounded by 2^32
  localparam int FRAC_W      = 32;
  localparam int QUO_W       = FRAC_W + 1;
  // integer square root of the quotient
  localparam int SQ_IN_W     = QUO_W + 1;
  localparam int ROOT_W      = SQ_IN_W / 2;
  localparam int SQ_REM_W    = ROOT_W + 2;
  localparam int SQ_CAND_W   = SQ_REM_W + 2;

  localparam logic [TINY_W-1:0] TINY_RESET = 21'd11;
  localparam logic [SIM_W-1:0]  SIM_POS_MAX = 16'h7FFF;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    degenerate;
    logic                    too_long;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } queue_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULP,
    BK_MULD,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/cs_fifo.sv =====
// small register queue that carries finished sums from front to back
// depends on cs_pkg for the status struct
`default_nettype none

module cs_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [DATA_W-1:0]   wdata,
  input  wire logic                pop,
  output logic [DATA_W-1:0]        rdata,
  output cs_pkg::queue_stat_t      stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    do_push = push & (cnt_r != CNT_W'(DEPTH));
    do_pop  = pop & (cnt_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.afull = (cnt_r == CNT_W'(DEPTH - 1));

endmodule

`default_nettype wire

// ===== src/cs_front.sv =====
// front end: takes element pairs, forms products and keeps the running sums
// depends on cs_pkg; hands each finished vector to the queue
`default_nettype none

module cs_front #(
  parameter int MAX_LEN = 64,
  parameter int CNT_W   = 7,
  parameter int NORM_W  = 37,
  parameter int DOT_W   = 38
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire cs_pkg::in_item_t     in_data,
  input  wire cs_pkg::queue_stat_t  q_stat,
  output logic                      q_push,
  output logic signed [DOT_W-1:0]   job_dot,
  output logic [NORM_W-1:0]         job_na,
  output logic [NORM_W-1:0]         job_nb,
  output logic                      job_ovf
);

  localparam int PROD_W = 2 * cs_pkg::ELEM_W;
  localparam int SQ_W   = PROD_W - 1;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     s1_vld_r, s1_last_r, s1_keep_r;
  logic signed [PROD_W-1:0] s1_ab_r;
  logic [SQ_W-1:0]          s1_aa_r, s1_bb_r;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic [NORM_W-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic                     ovf_r, ovf_nxt;

  logic                     accept, keep;
  logic signed [PROD_W-1:0] ab, aa, bb;
  logic signed [DOT_W-1:0]  dot_sum;
  logic [NORM_W-1:0]        na_sum, nb_sum;
  logic                     ovf_sum;

  assign full   = q_stat.full | (q_stat.afull & s1_vld_r & s1_last_r);
  assign accept = push & ~full;
  assign keep   = cnt_r < CNT_W'(MAX_LEN);
  assign ab     = in_data.a_elem * in_data.b_elem;
  assign aa     = in_data.a_elem * in_data.a_elem;
  assign bb     = in_data.b_elem * in_data.b_elem;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.last) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    dot_sum = dot_r + (s1_keep_r ? DOT_W'(s1_ab_r) : '0);
    na_sum  = na_r + (s1_keep_r ? NORM_W'(s1_aa_r) : '0);
    nb_sum  = nb_r + (s1_keep_r ? NORM_W'(s1_bb_r) : '0);
    ovf_sum = ovf_r | ~s1_keep_r;

    dot_nxt = dot_r;
    na_nxt  = na_r;
    nb_nxt  = nb_r;
    ovf_nxt = ovf_r;
    if (s1_vld_r) begin
      if (s1_last_r) begin
        dot_nxt = '0;
        na_nxt  = '0;
        nb_nxt  = '0;
        ovf_nxt = 1'b0;
      end else begin
        dot_nxt = dot_sum;
        na_nxt  = na_sum;
        nb_nxt  = nb_sum;
        ovf_nxt = ovf_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      dot_r    <= '0;
      na_r     <= '0;
      nb_r     <= '0;
      ovf_r    <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      s1_vld_r <= accept;
      dot_r    <= dot_nxt;
      na_r     <= na_nxt;
      nb_r     <= nb_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_data.last;
      s1_keep_r <= keep;
      s1_ab_r   <= ab;
      s1_aa_r   <= aa[SQ_W-1:0];
      s1_bb_r   <= bb[SQ_W-1:0];
    end
  end

  assign q_push  = s1_vld_r & s1_last_r;
  assign job_dot = dot_sum;
  assign job_na  = na_sum;
  assign job_nb  = nb_sum;
  assign job_ovf = ovf_sum;

endmodule

`default_nettype wire

// ===== src/cs_back.sv =====
// back end: norm product, dot square, long division and square root per vector
// depends on cs_pkg; holds the result register seen on the output queue side
`default_nettype none

module cs_back #(
  parameter int NORM_W = 37,
  parameter int DOT_W  = 38
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [cs_pkg::TINY_W-1:0] tiny_norm_sq,
  input  wire cs_pkg::queue_stat_t       q_stat,
  input  wire logic signed [DOT_W-1:0]   job_dot,
  input  wire logic [NORM_W-1:0]         job_na,
  input  wire logic [NORM_W-1:0]         job_nb,
  input  wire logic                      job_ovf,
  output logic                           q_pop,
  output logic                           empty,
  input  wire logic                      pop,
  output cs_pkg::out_item_t              out_data
);

  localparam int MUL_W  = 2 * NORM_W;
  localparam int REM_W  = MUL_W + 1;
  localparam int STEP_W = $clog2(NORM_W + cs_pkg::QUO_W + 1);
  localparam int QUO_W  = cs_pkg::QUO_W;
  localparam int FRAC_W = cs_pkg::FRAC_W;
  localparam int ROOT_W = cs_pkg::ROOT_W;
  localparam int SQI_W  = cs_pkg::SQ_IN_W;
  localparam int SQR_W  = cs_pkg::SQ_REM_W;
  localparam int SQC_W  = cs_pkg::SQ_CAND_W;
  localparam int SIM_W  = cs_pkg::SIM_W;

  cs_pkg::back_state_t state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MUL_W-1:0]    mc_r, mc_nxt;
  logic [NORM_W-1:0]   mp_r, mp_nxt;
  logic [MUL_W-1:0]    prod_r, prod_nxt;
  logic [MUL_W-1:0]    p_r, p_nxt;
  logic [NORM_W-1:0]   mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                ovf_r, ovf_nxt;
  logic                deg_r, deg_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [QUO_W-1:0]    dsh_r, dsh_nxt;
  logic [QUO_W-1:0]    qd_r, qd_nxt;
  logic [SQI_W-1:0]    sq_r, sq_nxt;
  logic [SQR_W-1:0]    srem_r, srem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic                out_vld_r, out_vld_nxt;
  cs_pkg::out_item_t   out_r, out_nxt;

  always_comb begin
    logic [MUL_W-1:0]  mul_sum;
    logic [DOT_W-1:0]  dot_abs;
    logic [NORM_W-1:0] tiny_ext;
    logic [REM_W-1:0]  div_cand;
    logic              div_bit;
    logic [QUO_W-1:0]  qd_fin;
    logic [SQC_W-1:0]  sq_cand;
    logic [SQC_W-1:0]  sq_trial;
    logic [ROOT_W-1:0] q_mag;
    logic [SIM_W-1:0]  sim_val;

    mul_sum  = mp_r[0] ? prod_r + mc_r : prod_r;
    dot_abs  = job_dot[DOT_W-1] ? DOT_W'(-job_dot) : DOT_W'(job_dot);
    tiny_ext = NORM_W'(tiny_norm_sq);
    div_cand = {rem_r[REM_W-2:0], dsh_r[QUO_W-1]};
    div_bit  = div_cand >= {1'b0, p_r};
    qd_fin   = {qd_r[QUO_W-2:0], div_bit};
    sq_cand  = {srem_r, sq_r[SQI_W-1 -: 2]};
    sq_trial = SQC_W'({root_r, 2'b01});
    q_mag    = ROOT_W'(({1'b0, root_r} + 1'b1) >> 1);
    if (deg_r) begin
      sim_val = '0;
    end else if (neg_r) begin
      sim_val = SIM_W'({1'b0, {(ROOT_W-1){1'b0}}} - q_mag);
    end else if (q_mag > ROOT_W'(cs_pkg::SIM_POS_MAX)) begin
      sim_val = cs_pkg::SIM_POS_MAX;
    end else begin
      sim_val = q_mag[SIM_W-1:0];
    end

    state_nxt   = state_r;
    step_nxt    = step_r;
    mc_nxt      = mc_r;
    mp_nxt      = mp_r;
    prod_nxt    = prod_r;
    p_nxt       = p_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    ovf_nxt     = ovf_r;
    deg_nxt     = deg_r;
    rem_nxt     = rem_r;
    dsh_nxt     = dsh_r;
    qd_nxt      = qd_r;
    sq_nxt      = sq_r;
    srem_nxt    = srem_r;
    root_nxt    = root_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~pop;
    q_pop       = 1'b0;

    unique case (state_r)
      cs_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          mc_nxt   = MUL_W'(job_na);
          mp_nxt   = job_nb;
          prod_nxt = '0;
          mag_nxt  = dot_abs[NORM_W-1:0];
          neg_nxt  = job_dot[DOT_W-1];
          ovf_nxt  = job_ovf;
          deg_nxt  = (job_na == '0) || (job_nb == '0) ||
                     (job_na < tiny_ext) || (job_nb < tiny_ext);
          step_nxt = STEP_W'(NORM_W);
          state_nxt = deg_nxt ? cs_pkg::BK_DONE : cs_pkg::BK_MULP;
        end
      end
      cs_pkg::BK_MULP: begin
        prod_nxt = mul_sum;
        mc_nxt   = mc_r << 1;
        mp_nxt   = mp_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          p_nxt     = mul_sum;
          prod_nxt  = '0;
          mc_nxt    = MUL_W'(mag_r);
          mp_nxt    = mag_r;
          step_nxt  = STEP_W'(NORM_W);
          state_nxt = cs_pkg::BK_MULD;
        end
      end
      cs_pkg::BK_MULD: begin
        prod_nxt = mul_sum;
        mc_nxt   = mc_r << 1;
        mp_nxt   = mp_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          rem_nxt   = REM_W'(mul_sum >> 1);
          dsh_nxt   = {mul_sum[0], {FRAC_W{1'b0}}};
          qd_nxt    = '0;
          step_nxt  = STEP_W'(QUO_W);
          state_nxt = cs_pkg::BK_DIV;
        end
      end
      cs_pkg::BK_DIV: begin
        rem_nxt  = div_bit ? div_cand - {1'b0, p_r} : div_cand;
        dsh_nxt  = dsh_r << 1;
        qd_nxt   = qd_fin;
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          sq_nxt    = SQI_W'(qd_fin);
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_W);
          state_nxt = cs_pkg::BK_SQRT;
        end
      end
      cs_pkg::BK_SQRT: begin
        if (sq_cand >= sq_trial) begin
          srem_nxt = SQR_W'(sq_cand - sq_trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = SQR_W'(sq_cand);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        sq_nxt   = sq_r << 2;
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          state_nxt = cs_pkg::BK_DONE;
        end
      end
      cs_pkg::BK_DONE: begin
        if (!out_vld_r || pop) begin
          out_vld_nxt         = 1'b1;
          out_nxt.similarity  = sim_val;
          out_nxt.degenerate  = deg_r;
          out_nxt.too_long    = ovf_r;
          state_nxt           = cs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = cs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cs_pkg::BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    prod_r <= prod_nxt;
    p_r    <= p_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    deg_r  <= deg_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    qd_r   <= qd_nxt;
    sq_r   <= sq_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    out_r  <= out_nxt;
  end

  assign empty    = ~out_vld_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== src/cosine_similarity_core.sv =====
// Streaming cosine similarity of two Q1.15 vectors, one element pair per
// transfer. The front end takes a pair every cycle while full is low and
// keeps the sums of a*b, a*a and b*b; pairs beyond MAX_LEN are dropped and
// flagged too_long. When the last pair is summed the three sums go into a
// two-entry queue and the back end works on them: it picks up the job, runs
// a shift-add multiply of the two norms (NORM_W = 31 + clog2(MAX_LEN), 37 at
// the default), a shift-add square of the dot product, a 33-step restoring
// division and a 17-step integer square root, and writes the result
// register. When a norm is zero or below tiny_norm_sq the arithmetic is
// skipped and the result is zero with degenerate set. The back end sets the
// sustained rate for short vectors. The result is rounded half away from
// zero and clamped to 0x7fff.
// depends on cs_pkg, cs_fifo, cs_front and cs_back
`default_nettype none

module cosine_similarity_core #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire cs_pkg::in_item_t          in_data,
  output logic                           empty,
  input  wire logic                      pop,
  output cs_pkg::out_item_t              out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [cs_pkg::TINY_W-1:0] cfg_wr_data
);

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int NORM_W = 2 * cs_pkg::ELEM_W - 1 + $clog2(MAX_LEN);
  localparam int DOT_W  = NORM_W + 1;
  localparam int JOB_W  = DOT_W + 2 * NORM_W + 1;

  logic [cs_pkg::TINY_W-1:0] tiny_r;
  cs_pkg::queue_stat_t       q_stat;
  logic                      q_push, q_pop;
  logic signed [DOT_W-1:0]   f_dot, b_dot;
  logic [NORM_W-1:0]         f_na, f_nb, b_na, b_nb;
  logic                      f_ovf, b_ovf;
  logic [JOB_W-1:0]          q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiny_r <= cs_pkg::TINY_RESET;
    end else if (cfg_wr_en) begin
      tiny_r <= cfg_wr_data;
    end
  end

  cs_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .NORM_W  (NORM_W),
    .DOT_W   (DOT_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .job_dot (f_dot),
    .job_na  (f_na),
    .job_nb  (f_nb),
    .job_ovf (f_ovf)
  );

  assign q_wdata = {f_dot, f_na, f_nb, f_ovf};

  cs_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (cs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign {b_dot, b_na, b_nb, b_ovf} = q_rdata;

  cs_back #(
    .NORM_W (NORM_W),
    .DOT_W  (DOT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tiny_norm_sq (tiny_r),
    .q_stat       (q_stat),
    .job_dot      (b_dot),
    .job_na       (b_na),
    .job_nb       (b_nb),
    .job_ovf      (b_ovf),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
